// ===== rtl/ip6hp_pkg.sv =====
package ip6hp_pkg;

  localparam int unsigned POS_W = 17;
  localparam logic [POS_W-1:0] POS_MAX   = '1;
  localparam logic [POS_W-1:0] HDR_BYTES = 17'd40;
  localparam logic [POS_W-1:0] HDR_LAST  = HDR_BYTES - 17'd1;

  localparam logic [POS_W-1:0] POS_VERSION = 17'd0;
  localparam logic [POS_W-1:0] POS_LEN_HI  = 17'd4;
  localparam logic [POS_W-1:0] POS_LEN_LO  = 17'd5;
  localparam logic [POS_W-1:0] POS_NEXT    = 17'd6;
  localparam logic [POS_W-1:0] POS_HOP     = 17'd7;

  localparam logic [3:0] IPV6_VER = 4'd6;

  // Next-header codes
  localparam logic [7:0] NH_HOPOPT  = 8'd0;
  localparam logic [7:0] NH_TCP     = 8'd6;
  localparam logic [7:0] NH_UDP     = 8'd17;
  localparam logic [7:0] NH_ROUTING = 8'd43;
  localparam logic [7:0] NH_FRAG    = 8'd44;
  localparam logic [7:0] NH_AH      = 8'd51;
  localparam logic [7:0] NH_ICMPV6  = 8'd58;
  localparam logic [7:0] NH_NONE    = 8'd59;
  localparam logic [7:0] NH_DSTOPT  = 8'd60;

  // Extension header sizing: length byte sits one past the start
  localparam logic [POS_W-1:0] EXT_MIN_BYTES = 17'd2;
  localparam logic [POS_W-1:0] FRAG_BYTES    = 17'd8;
  localparam logic [POS_W-1:0] AH_LEN_BIAS   = 17'd2;
  localparam logic [POS_W-1:0] EXT_LEN_BIAS  = 17'd1;
  localparam int unsigned      AH_UNIT_SH    = 2;
  localparam int unsigned      EXT_UNIT_SH   = 3;

  localparam int unsigned Q_DEPTH = 4;
  localparam int unsigned Q_AW    = $clog2(Q_DEPTH);
  localparam int unsigned Q_CW    = $clog2(Q_DEPTH + 1);

  typedef enum logic [2:0] {
    K_VERSION = 3'd0,
    K_LEN_HI  = 3'd1,
    K_LEN_LO  = 3'd2,
    K_NEXT    = 3'd3,
    K_HOP     = 3'd4,
    K_PAYLOAD = 3'd5,
    K_SKIP    = 3'd6
  } kind_t;

  typedef enum logic [3:0] {
    V_ICMPV6  = 4'd0,
    V_TCP     = 4'd1,
    V_UDP     = 4'd2,
    V_NONE    = 4'd3,
    V_UNKNOWN = 4'd4,
    V_SHORT   = 4'd5,
    V_VERSION = 4'd6,
    V_LENGTH  = 4'd7,
    V_HOPZERO = 4'd8,
    V_TRUNC   = 4'd9
  } verdict_t;

  typedef enum logic [3:0] {
    OUT_PENDING = 4'b0001,
    OUT_UPPER   = 4'b0010,
    OUT_NONE    = 4'b0100,
    OUT_TRUNC   = 4'b1000
  } outcome_t;

  typedef struct packed {
    logic [7:0]       data_byte;
    logic             last_byte;
    kind_t            kind;
    logic [POS_W-1:0] pos;
  } entry_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

endpackage

// ===== rtl/ip6hp_if.sv =====
interface ip6hp_pkt_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;

  modport source (output valid, data_byte, last_byte, input ready);
  modport sink (input valid, data_byte, last_byte, output ready);
endinterface

interface ip6hp_res_if;
  logic        valid;
  logic        ready;
  logic [3:0]  verdict;
  logic [7:0]  upper_protocol;
  logic [15:0] upper_offset;
  logic [15:0] payload_length;

  modport source (output valid, verdict, upper_protocol, upper_offset, payload_length,
                  input ready);
  modport sink (input valid, verdict, upper_protocol, upper_offset, payload_length,
                output ready);
endinterface

// ===== rtl/ip6hp_front.sv =====
module ip6hp_front import ip6hp_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  ip6hp_pkt_if.sink   pkt,
  input  q_stat_t     q_stat,
  output logic        push,
  output entry_t      push_entry
);

  logic [POS_W-1:0] pos;
  kind_t            kind;

  assign pkt.ready = !q_stat.full;
  assign push      = pkt.valid && !q_stat.full;

  // tag each byte by its place in the packet
  always_comb begin
    if (pos == POS_VERSION) begin
      kind = K_VERSION;
    end else if (pos == POS_LEN_HI) begin
      kind = K_LEN_HI;
    end else if (pos == POS_LEN_LO) begin
      kind = K_LEN_LO;
    end else if (pos == POS_NEXT) begin
      kind = K_NEXT;
    end else if (pos == POS_HOP) begin
      kind = K_HOP;
    end else if (pos >= HDR_BYTES) begin
      kind = K_PAYLOAD;
    end else begin
      kind = K_SKIP;
    end
  end

  assign push_entry = '{data_byte: pkt.data_byte, last_byte: pkt.last_byte,
                        kind: kind, pos: pos};

  // advance and saturate; restart at the packet boundary
  always_ff @(posedge clk) begin
    if (rst) begin
      pos <= '0;
    end else if (push) begin
      if (pkt.last_byte) begin
        pos <= '0;
      end else if (pos != POS_MAX) begin
        pos <= pos + 17'd1;
      end
    end
  end

endmodule

// ===== rtl/ip6hp_queue.sv =====
module ip6hp_queue import ip6hp_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    push,
  input  entry_t  push_entry,
  input  logic    pop,
  output entry_t  pop_entry,
  output q_stat_t q_stat
);

  entry_t          mem [Q_DEPTH];
  logic [Q_AW-1:0] wr_ptr;
  logic [Q_AW-1:0] rd_ptr;
  logic [Q_CW-1:0] count;

  assign pop_entry    = mem[rd_ptr];
  assign q_stat.full  = (count == Q_CW'(Q_DEPTH));
  assign q_stat.empty = (count == '0);

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + Q_AW'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + Q_AW'(1);
      end
      if (push && !pop) begin
        count <= count + Q_CW'(1);
      end else if (pop && !push) begin
        count <= count - Q_CW'(1);
      end
    end
  end

endmodule

// ===== rtl/ip6hp_back.sv =====
module ip6hp_back import ip6hp_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  entry_t       entry,
  input  q_stat_t      q_stat,
  output logic         pop,
  ip6hp_res_if.source  result
);

  logic [3:0]       version, version_next;
  logic [15:0]      plen, plen_next;
  logic [7:0]       hop, hop_next;
  logic [7:0]       nh, nh_next;
  logic [POS_W-1:0] start, start_next;
  outcome_t         outcome, outcome_next;
  logic             len_wait, len_wait_next;
  logic [7:0]       pend_nh, pend_nh_next;

  logic             out_valid;
  verdict_t         out_verdict, verdict_c;
  logic [7:0]       out_proto, proto_c;
  logic [15:0]      out_offset, offset_c;
  logic [15:0]      out_plen;

  logic [POS_W-1:0] payoff;
  logic [POS_W-1:0] hdr_len;
  logic             in_payload;
  logic             is_var_ext;

  assign pop = !q_stat.empty && (!entry.last_byte || !out_valid || result.ready);

  assign payoff     = entry.pos - HDR_BYTES;
  assign in_payload = (entry.kind == K_PAYLOAD) && (payoff < {1'b0, plen_next});
  assign is_var_ext = (nh == NH_HOPOPT) || (nh == NH_ROUTING) ||
                      (nh == NH_DSTOPT) || (nh == NH_AH);
  assign hdr_len    = (nh == NH_AH)
                      ? ((POS_W'(entry.data_byte) + AH_LEN_BIAS) << AH_UNIT_SH)
                      : ((POS_W'(entry.data_byte) + EXT_LEN_BIAS) << EXT_UNIT_SH);

  // header capture and one step of the chain walk
  always_comb begin
    version_next  = version;
    plen_next     = plen;
    hop_next      = hop;
    nh_next       = nh;
    start_next    = start;
    outcome_next  = outcome;
    len_wait_next = len_wait;
    pend_nh_next  = pend_nh;

    unique case (entry.kind) inside
      K_VERSION:         version_next = entry.data_byte[7:4];
      K_LEN_HI:          plen_next    = {entry.data_byte, plen[7:0]};
      K_LEN_LO:          plen_next    = {plen[15:8], entry.data_byte};
      K_NEXT:            nh_next      = entry.data_byte;
      K_HOP:             hop_next     = entry.data_byte;
      K_PAYLOAD, K_SKIP: ;
      default:           ;
    endcase

    if (in_payload && (outcome == OUT_PENDING)) begin
      if (len_wait) begin
        if (payoff == start + 17'd1) begin
          start_next    = start + hdr_len;
          nh_next       = pend_nh;
          len_wait_next = 1'b0;
        end
      end else if (payoff == start) begin
        if (is_var_ext) begin
          if (start + EXT_MIN_BYTES > {1'b0, plen}) begin
            outcome_next = OUT_TRUNC;
          end else begin
            pend_nh_next  = entry.data_byte;
            len_wait_next = 1'b1;
          end
        end else if (nh == NH_FRAG) begin
          if (start + FRAG_BYTES > {1'b0, plen}) begin
            outcome_next = OUT_TRUNC;
          end else begin
            start_next = start + FRAG_BYTES;
            nh_next    = entry.data_byte;
          end
        end else if (nh == NH_NONE) begin
          outcome_next = OUT_NONE;
        end else begin
          outcome_next = OUT_UPPER;
        end
      end
    end
  end

  // verdict, checks in priority order
  always_comb begin
    proto_c  = '0;
    offset_c = '0;
    if (entry.pos < HDR_LAST) begin
      verdict_c = V_SHORT;
    end else if (version_next != IPV6_VER) begin
      verdict_c = V_VERSION;
    end else if ({1'b0, plen_next} + HDR_LAST > entry.pos) begin
      verdict_c = V_LENGTH;
    end else if (hop_next == '0) begin
      verdict_c = V_HOPZERO;
    end else begin
      unique case (outcome_next)
        OUT_UPPER: begin
          proto_c  = nh_next;
          offset_c = start_next[15:0];
          if (nh_next == NH_ICMPV6) begin
            verdict_c = V_ICMPV6;
          end else if (nh_next == NH_TCP) begin
            verdict_c = V_TCP;
          end else if (nh_next == NH_UDP) begin
            verdict_c = V_UDP;
          end else begin
            verdict_c = V_UNKNOWN;
          end
        end
        OUT_NONE: begin
          verdict_c = V_NONE;
          proto_c   = NH_NONE;
          offset_c  = start_next[15:0];
        end
        default: verdict_c = V_TRUNC;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      version   <= '0;
      plen      <= '0;
      hop       <= '0;
      nh        <= '0;
      start     <= '0;
      outcome   <= OUT_PENDING;
      len_wait  <= 1'b0;
      pend_nh   <= '0;
      out_valid <= 1'b0;
    end else begin
      // a new verdict replaces the one leaving in the same cycle
      if (pop && entry.last_byte) begin
        out_valid <= 1'b1;
      end else if (out_valid && result.ready) begin
        out_valid <= 1'b0;
      end
      if (pop) begin
        if (entry.last_byte) begin
          version   <= '0;
          plen      <= '0;
          hop       <= '0;
          nh        <= '0;
          start     <= '0;
          outcome   <= OUT_PENDING;
          len_wait  <= 1'b0;
          pend_nh   <= '0;
        end else begin
          version  <= version_next;
          plen     <= plen_next;
          hop      <= hop_next;
          nh       <= nh_next;
          start    <= start_next;
          outcome  <= outcome_next;
          len_wait <= len_wait_next;
          pend_nh  <= pend_nh_next;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop && entry.last_byte) begin
      out_verdict <= verdict_c;
      out_proto   <= proto_c;
      out_offset  <= offset_c;
      out_plen    <= plen_next;
    end
  end

  assign result.valid          = out_valid;
  assign result.verdict        = out_verdict;
  assign result.upper_protocol = out_proto;
  assign result.upper_offset   = out_offset;
  assign result.payload_length = out_plen;

endmodule

// ===== rtl/ipv6_receive_header_chain_parser_core.sv =====
// Channel  | Dir | Handshake       | Request contents
// ---------+-----+-----------------+-------------------------------------------------
// pkt      | in  | valid / ready   | data_byte, last_byte: one packet byte
// result   | out | valid / ready   | verdict, upper_protocol, upper_offset,
//          |     |                 | payload_length: one per packet, at its last byte
//
// Takes one byte every cycle while the queue has room. The last byte is written into
// the four-entry queue; the walker pops it and registers the verdict at that pop, so
// the verdict stays in its output register until result takes it.
// Reset (rst, synchronous, active high) empties the queue and clears the walker.
// The walker stalls only on a last byte while the previous verdict waits; the front
// keeps taking bytes until the queue fills, then drops ready.

module ipv6_receive_header_chain_parser_core import ip6hp_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  ip6hp_pkt_if.sink   pkt,
  ip6hp_res_if.source result
);

  logic    push;
  logic    pop;
  entry_t  push_entry;
  entry_t  pop_entry;
  q_stat_t q_stat;

  // front: count position and classify each byte
  ip6hp_front u_front (
    .clk        (clk),
    .rst        (rst),
    .pkt        (pkt),
    .q_stat     (q_stat),
    .push       (push),
    .push_entry (push_entry)
  );

  // hold classified bytes so either side can stall alone
  ip6hp_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .pop        (pop),
    .pop_entry  (pop_entry),
    .q_stat     (q_stat)
  );

  // back: capture header fields, walk the chain, deliver the verdict
  ip6hp_back u_back (
    .clk    (clk),
    .rst    (rst),
    .entry  (pop_entry),
    .q_stat (q_stat),
    .pop    (pop),
    .result (result)
  );

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push |-> !q_stat.full)
    else $error("byte pushed into a full queue");

  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    pop |-> !q_stat.empty)
    else $error("walker popped an empty queue");

  a_offset_in_payload: assert property (@(posedge clk) disable iff (rst)
    (result.valid && (result.verdict <= V_UNKNOWN)) |->
      (result.upper_offset < result.payload_length))
    else $error("upper offset outside the payload");

  a_error_fields_clear: assert property (@(posedge clk) disable iff (rst)
    (result.valid && (result.verdict > V_UNKNOWN)) |->
      ((result.upper_protocol == '0) && (result.upper_offset == '0)))
    else $error("error verdict carries a protocol or offset");

  a_reset_idle: assert property (@(posedge clk) disable iff (rst)
    $past(rst) |-> !result.valid)
    else $error("verdict shown straight after reset");

endmodule
